@@ design/cwm_pkg.sv @@
// ----------------------------------------------------------------------------
// cwm_pkg
// Shared types, constants and tables of the cylindrical warp map generator.
// ----------------------------------------------------------------------------
package cwm_pkg;

    localparam int FRAC_BITS    = 8;
    localparam int CORDIC_STEPS = 30;
    localparam int ANGLE_BITS   = 31;   // quotient bits of the angle divider
    localparam int MAG_BITS     = 21;   // quotient bits of the magnitude dividers
    localparam int CS_W         = 34;   // cordic x/y width
    localparam int Z_W          = 33;   // cordic angle accumulator width

    localparam logic [ANGLE_BITS-1:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // input register, angle divider, cordic, multiply, divider setup,
    // magnitude divider, output register
    localparam int LATENCY = 1 + ANGLE_BITS + CORDIC_STEPS + 2 + MAG_BITS + 1;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FOCAL_LENGTH = 2'd2;

    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
    } req_t;

    typedef struct packed {
        logic [19:0] src_x;
        logic [19:0] src_y;
        logic        in_range;
    } rsp_t;

    // sideband that travels with each item through the pipeline
    typedef struct packed {
        logic        bad;
        logic        neg_x;
        logic        neg_y;
        logic [11:0] acy;
    } side_t;

    // atan(2^-i) in Q30
    function automatic logic [29:0] atan_q30(input int unsigned i);
        logic [29:0] v;
        unique case (i)
            0:  v = 30'd843314857;
            1:  v = 30'd497837829;
            2:  v = 30'd263043837;
            3:  v = 30'd133525159;
            4:  v = 30'd67021687;
            5:  v = 30'd33543516;
            6:  v = 30'd16775851;
            7:  v = 30'd8388437;
            8:  v = 30'd4194283;
            9:  v = 30'd2097149;
            10: v = 30'd1048576;
            11: v = 30'd524288;
            12: v = 30'd262144;
            13: v = 30'd131072;
            14: v = 30'd65536;
            15: v = 30'd32768;
            16: v = 30'd16384;
            17: v = 30'd8192;
            18: v = 30'd4096;
            19: v = 30'd2048;
            20: v = 30'd1024;
            21: v = 30'd512;
            22: v = 30'd256;
            23: v = 30'd128;
            24: v = 30'd64;
            25: v = 30'd32;
            26: v = 30'd16;
            27: v = 30'd8;
            28: v = 30'd4;
            29: v = 30'd2;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

@@ design/cwm_cordic.sv @@
// ----------------------------------------------------------------------------
// cwm_cordic
// Fully pipelined rotation-mode cordic, one micro-rotation per stage.
// ----------------------------------------------------------------------------
module cwm_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [cwm_pkg::ANGLE_BITS-1:0]      angle,
    input  cwm_pkg::side_t                      in_side,
    output logic                                out_valid,
    output logic signed [cwm_pkg::CS_W-1:0]     cos_val,
    output logic signed [cwm_pkg::CS_W-1:0]     sin_val,
    output cwm_pkg::side_t                      out_side
);

    logic                              v_reg    [1:cwm_pkg::CORDIC_STEPS];
    logic signed [cwm_pkg::CS_W-1:0]   x_reg    [1:cwm_pkg::CORDIC_STEPS];
    logic signed [cwm_pkg::CS_W-1:0]   y_reg    [1:cwm_pkg::CORDIC_STEPS];
    logic signed [cwm_pkg::Z_W-1:0]    z_reg    [1:cwm_pkg::CORDIC_STEPS];
    cwm_pkg::side_t                    side_reg [1:cwm_pkg::CORDIC_STEPS];

    for (genvar k = 0; k < cwm_pkg::CORDIC_STEPS; k++)
    begin : g_stage
        logic                            v_prev;
        logic signed [cwm_pkg::CS_W-1:0] x_prev;
        logic signed [cwm_pkg::CS_W-1:0] y_prev;
        logic signed [cwm_pkg::Z_W-1:0]  z_prev;
        cwm_pkg::side_t                  s_prev;
        logic signed [cwm_pkg::Z_W-1:0]  step;

        if (k == 0)
        begin : g_first
            assign v_prev = in_valid;
            assign x_prev = cwm_pkg::CORDIC_GAIN;
            assign y_prev = '0;
            assign z_prev = signed'({{(cwm_pkg::Z_W-cwm_pkg::ANGLE_BITS){1'b0}}, angle});
            assign s_prev = in_side;
        end
        else
        begin : g_later
            assign v_prev = v_reg[k];
            assign x_prev = x_reg[k];
            assign y_prev = y_reg[k];
            assign z_prev = z_reg[k];
            assign s_prev = side_reg[k];
        end

        assign step = signed'({3'b000, cwm_pkg::atan_q30(k)});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg[k+1] <= s_prev;
            if (z_prev >= 0)
            begin
                x_reg[k+1] <= x_prev - (y_prev >>> k);
                y_reg[k+1] <= y_prev + (x_prev >>> k);
                z_reg[k+1] <= z_prev - step;
            end
            else
            begin
                x_reg[k+1] <= x_prev + (y_prev >>> k);
                y_reg[k+1] <= y_prev - (x_prev >>> k);
                z_reg[k+1] <= z_prev + step;
            end
        end
    end

    assign out_valid = v_reg[cwm_pkg::CORDIC_STEPS];
    assign cos_val   = x_reg[cwm_pkg::CORDIC_STEPS];
    assign sin_val   = y_reg[cwm_pkg::CORDIC_STEPS];
    assign out_side  = side_reg[cwm_pkg::CORDIC_STEPS];

endmodule

@@ design/cylindrical_warp_map_generator.sv @@
// ----------------------------------------------------------------------------
// cylindrical_warp_map_generator
// Cylindrical projection remap: destination pixel to source coordinate.
// ----------------------------------------------------------------------------
// One coordinate is taken per clock cycle and its result appears on rsp with
// done high; busy never rises, since the whole path is a free-running
// pipeline: a 31-stage restoring divider for the angle, 30 cordic stages, a
// multiply stage, a setup stage and two 21-stage restoring dividers for the
// magnitudes, each divider or cordic stage one quotient bit or one rotation.
// The receiver cannot stall, so every result must be taken in the cycle that
// done is high. The user must write registers over the apb port only while no
// item is in flight; the block itself does not enforce it.
module cylindrical_warp_map_generator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  cwm_pkg::req_t req,
    output logic          done,
    output cwm_pkg::rsp_t rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int A = cwm_pkg::ANGLE_BITS;
    localparam int M = cwm_pkg::MAG_BITS;

    // configuration
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [17:0] focal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            focal_reg  <= 18'd8000;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                cwm_pkg::REG_IMAGE_WIDTH:  width_reg  <= pwdata[12:0];
                cwm_pkg::REG_IMAGE_HEIGHT: height_reg <= pwdata[12:0];
                cwm_pkg::REG_FOCAL_LENGTH: focal_reg  <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            cwm_pkg::REG_IMAGE_WIDTH:  prdata = {19'd0, width_reg};
            cwm_pkg::REG_IMAGE_HEIGHT: prdata = {19'd0, height_reg};
            cwm_pkg::REG_FOCAL_LENGTH: prdata = {14'd0, focal_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;
    assign busy   = 1'b0;

    // input stage: centre offsets and out-of-map checks
    logic [11:0] hw;
    logic [11:0] hh;
    logic        neg_x;
    logic        neg_y;
    logic [11:0] acx;
    logic [11:0] acy;
    logic        bad0;

    assign hw    = width_reg[12:1];
    assign hh    = height_reg[12:1];
    assign neg_x = req.col < hw;
    assign neg_y = req.row < hh;
    assign acx   = neg_x ? hw - req.col : req.col - hw;
    assign acy   = neg_y ? hh - req.row : req.row - hh;
    // angle of 2 or more in Q30 can never be below a right angle
    assign bad0  = ({1'b0, req.col} >= {hw, 1'b0}) || ({1'b0, req.row} >= {hh, 1'b0})
                   || (focal_reg == 18'd0)
                   || ({3'b000, acx, 3'b000} >= focal_reg);

    // angle divider: a = (acx << 34) / f, one quotient bit per stage
    logic           d1_v_reg    [0:A];
    logic [17:0]    d1_r_reg    [0:A];
    logic [A-1:0]   d1_q_reg    [0:A];
    cwm_pkg::side_t d1_side_reg [0:A];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_v_reg[0] <= 1'b0;
        end
        else
        begin
            d1_v_reg[0] <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_r_reg[0]          <= {3'b000, acx, 3'b000};
        d1_q_reg[0]          <= '0;
        d1_side_reg[0].bad   <= bad0;
        d1_side_reg[0].neg_x <= neg_x;
        d1_side_reg[0].neg_y <= neg_y;
        d1_side_reg[0].acy   <= acy;
    end

    for (genvar k = 1; k <= A; k++)
    begin : g_div1
        logic [18:0] t;
        logic [18:0] diff;
        logic        ge;

        assign t    = {d1_r_reg[k-1], 1'b0};
        assign diff = t - {1'b0, focal_reg};
        assign ge   = t >= {1'b0, focal_reg};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d1_v_reg[k] <= 1'b0;
            end
            else
            begin
                d1_v_reg[k] <= d1_v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            d1_r_reg[k]    <= ge ? diff[17:0] : t[17:0];
            d1_q_reg[k]    <= {d1_q_reg[k-1][A-2:0], ge};
            d1_side_reg[k] <= d1_side_reg[k-1];
        end
    end

    cwm_pkg::side_t cin_side;

    always_comb
    begin
        cin_side     = d1_side_reg[A];
        cin_side.bad = d1_side_reg[A].bad || (d1_q_reg[A] >= cwm_pkg::HALF_PI_Q30);
    end

    logic                            c_v;
    logic signed [cwm_pkg::CS_W-1:0] c_cos;
    logic signed [cwm_pkg::CS_W-1:0] c_sin;
    cwm_pkg::side_t                  c_side;

    cwm_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_v_reg[A]),
        .angle     (d1_q_reg[A]),
        .in_side   (cin_side),
        .out_valid (c_v),
        .cos_val   (c_cos),
        .sin_val   (c_sin),
        .out_side  (c_side)
    );

    // multiply stage: f * sin
    logic           m1_v_reg;
    logic [48:0]    m1_p_reg;
    logic [32:0]    m1_c_reg;
    cwm_pkg::side_t m1_side_reg;
    cwm_pkg::side_t m1_side;
    logic [30:0]    s_clamp;

    assign s_clamp = (c_sin < 0) ? 31'd0 : c_sin[30:0];

    always_comb
    begin
        m1_side     = c_side;
        m1_side.bad = c_side.bad || (c_cos <= 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
        end
        else
        begin
            m1_v_reg <= c_v;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_p_reg    <= focal_reg * s_clamp;
        m1_c_reg    <= c_cos[32:0];
        m1_side_reg <= m1_side;
    end

    // magnitude dividers: quotients of 2^21 or more are out of range anyway
    logic           d2_v_reg    [0:M];
    logic [32:0]    d2_c_reg    [0:M];
    logic [32:0]    d2_rx_reg   [0:M];
    logic [32:0]    d2_ry_reg   [0:M];
    logic [M-1:0]   d2_lo_reg   [0:M];
    logic [M-1:0]   d2_qx_reg   [0:M];
    logic [M-1:0]   d2_qy_reg   [0:M];
    cwm_pkg::side_t d2_side_reg [0:M];
    cwm_pkg::side_t d2_side;

    logic ovx;
    logic ovy;

    assign ovx = {1'b0, m1_p_reg, 4'b0000} >= {m1_c_reg, 21'd0};
    assign ovy = {4'b0000, m1_side_reg.acy, 17'd0} >= m1_c_reg;

    always_comb
    begin
        d2_side     = m1_side_reg;
        d2_side.bad = m1_side_reg.bad || ovx || ovy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d2_v_reg[0] <= 1'b0;
        end
        else
        begin
            d2_v_reg[0] <= m1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d2_c_reg[0]    <= m1_c_reg;
        d2_rx_reg[0]   <= {1'b0, m1_p_reg[48:17]};
        d2_ry_reg[0]   <= {4'b0000, m1_side_reg.acy, 17'd0};
        d2_lo_reg[0]   <= {m1_p_reg[16:0], 4'b0000};
        d2_qx_reg[0]   <= '0;
        d2_qy_reg[0]   <= '0;
        d2_side_reg[0] <= d2_side;
    end

    for (genvar k = 1; k <= M; k++)
    begin : g_div2
        logic [33:0] tx;
        logic [33:0] ty;
        logic [33:0] dx;
        logic [33:0] dy;
        logic        gex;
        logic        gey;

        assign tx  = {d2_rx_reg[k-1], d2_lo_reg[k-1][M-1]};
        assign ty  = {d2_ry_reg[k-1], 1'b0};
        assign dx  = tx - {1'b0, d2_c_reg[k-1]};
        assign dy  = ty - {1'b0, d2_c_reg[k-1]};
        assign gex = tx >= {1'b0, d2_c_reg[k-1]};
        assign gey = ty >= {1'b0, d2_c_reg[k-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d2_v_reg[k] <= 1'b0;
            end
            else
            begin
                d2_v_reg[k] <= d2_v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            d2_c_reg[k]    <= d2_c_reg[k-1];
            d2_rx_reg[k]   <= gex ? dx[32:0] : tx[32:0];
            d2_ry_reg[k]   <= gey ? dy[32:0] : ty[32:0];
            d2_lo_reg[k]   <= {d2_lo_reg[k-1][M-2:0], 1'b0};
            d2_qx_reg[k]   <= {d2_qx_reg[k-1][M-2:0], gex};
            d2_qy_reg[k]   <= {d2_qy_reg[k-1][M-2:0], gey};
            d2_side_reg[k] <= d2_side_reg[k-1];
        end
    end

    // output stage: offset from the image centre and range check
    logic [20:0]    limw;
    logic [20:0]    limh;
    logic [19:0]    halfw;
    logic [19:0]    halfh;
    logic [22:0]    sx;
    logic [22:0]    sy;
    logic           ok;
    cwm_pkg::side_t fs;
    logic [M-1:0]   mx;
    logic [M-1:0]   my;

    assign fs    = d2_side_reg[M];
    assign mx    = d2_qx_reg[M];
    assign my    = d2_qy_reg[M];
    assign limw  = 21'(width_reg) << cwm_pkg::FRAC_BITS;
    assign limh  = 21'(height_reg) << cwm_pkg::FRAC_BITS;
    assign halfw = 20'(width_reg) << (cwm_pkg::FRAC_BITS - 1);
    assign halfh = 20'(height_reg) << (cwm_pkg::FRAC_BITS - 1);
    assign sx    = fs.neg_x ? {3'b000, halfw} - {2'b00, mx} : {3'b000, halfw} + {2'b00, mx};
    assign sy    = fs.neg_y ? {3'b000, halfh} - {2'b00, my} : {3'b000, halfh} + {2'b00, my};
    assign ok    = !fs.bad && (mx <= limw) && (my <= limh)
                   && !sx[22] && (sx[21:0] < {1'b0, limw})
                   && !sy[22] && (sy[21:0] < {1'b0, limh});

    logic          done_reg;
    cwm_pkg::rsp_t rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d2_v_reg[M];
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg.src_x    <= ok ? sx[19:0] : 20'd0;
        rsp_reg.src_y    <= ok ? sy[19:0] : 20'd0;
        rsp_reg.in_range <= ok;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(cwm_pkg::LATENCY) done)
        else $error("transfer did not produce a result after the pipeline latency");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, cwm_pkg::LATENCY))
        else $error("result without a matching input transfer");

    a_zero_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        done && !rsp.in_range |-> rsp.src_x == 20'd0 && rsp.src_y == 20'd0)
        else $error("out-of-range result carries nonzero coordinates");
`endif

endmodule

@@ tb/cwm_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cwm_checker
// Watches the command and result channels and the register port of the warp
// map generator. For every accepted coordinate it computes the expected source
// coordinate in fixed point and compares it field by field with each result.
// ----------------------------------------------------------------------------
module cwm_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  cwm_pkg::req_t req,
    input  logic          done,
    input  cwm_pkg::rsp_t rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    input  logic          pready,
    output int            fail_count,
    output int            pending,
    output int            mapped_count,
    output int            result_count
);

    localparam longint ARC_LIMIT = 64'd1686629713;

    logic [12:0]   width_q;
    logic [12:0]   height_q;
    logic [17:0]   focal_q;
    cwm_pkg::rsp_t coord_queue[$];

    function automatic longint ashr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic cwm_pkg::rsp_t map_coord(input cwm_pkg::req_t r);
        cwm_pkg::rsp_t o;
        longint hw, hh, cx, cy, ang, x, y, z, xs, ys, sx, sy;
        longint halfw, halfh, limw, limh;
        longint unsigned acx, acy, mx, my;
        o  = '0;
        hw = longint'(width_q >> 1);
        hh = longint'(height_q >> 1);
        halfw = longint'(width_q) << (cwm_pkg::FRAC_BITS - 1);
        halfh = longint'(height_q) << (cwm_pkg::FRAC_BITS - 1);
        limw  = longint'(width_q) << cwm_pkg::FRAC_BITS;
        limh  = longint'(height_q) << cwm_pkg::FRAC_BITS;
        if (longint'(r.col) >= 2 * hw || longint'(r.row) >= 2 * hh || focal_q == 0)
            return o;
        cx  = longint'(r.col) - hw;
        cy  = longint'(r.row) - hh;
        acx = (cx < 0) ? -cx : cx;
        acy = (cy < 0) ? -cy : cy;
        ang = longint'((acx << 34) / longint'(focal_q));
        if (ang >= ARC_LIMIT)
            return o;
        x = longint'(cwm_pkg::CORDIC_GAIN);
        y = 0;
        z = ang;
        for (int i = 0; i < cwm_pkg::CORDIC_STEPS; i++)
        begin
            xs = ashr(x, i);
            ys = ashr(y, i);
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - longint'(cwm_pkg::atan_q30(i));
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + longint'(cwm_pkg::atan_q30(i));
            end
        end
        if (x <= 0)
            return o;
        if (y < 0)
            y = 0;
        mx = ((longint'(focal_q) * y) << (cwm_pkg::FRAC_BITS - 4)) / x;
        my = (acy << (cwm_pkg::FRAC_BITS + 30)) / x;
        if (mx > limw || my > limh)
            return o;
        sx = (cx < 0) ? halfw - longint'(mx) : halfw + longint'(mx);
        sy = (cy < 0) ? halfh - longint'(my) : halfh + longint'(my);
        if (sx < 0 || sx >= limw || sy < 0 || sy >= limh)
            return o;
        o.src_x    = sx[19:0];
        o.src_y    = sy[19:0];
        o.in_range = 1'b1;
        return o;
    endfunction

    assign pending = coord_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        cwm_pkg::rsp_t want;
        if (!rst_n)
        begin
            width_q      <= 13'd640;
            height_q     <= 13'd480;
            focal_q      <= 18'd8000;
            fail_count   <= 0;
            mapped_count <= 0;
            result_count <= 0;
            coord_queue.delete();
        end
        else
        begin
            if (done)
            begin
                result_count <= result_count + 1;
                if (coord_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result x=%0d y=%0d ok=%0d",
                                 rsp.src_x, rsp.src_y, rsp.in_range);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = coord_queue.pop_front();
                    if (want.in_range)
                        mapped_count <= mapped_count + 1;
                    if (rsp !== want)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp x=%0d y=%0d ok=%0d got x=%0d y=%0d ok=%0d",
                                     want.src_x, want.src_y, want.in_range,
                                     rsp.src_x, rsp.src_y, rsp.in_range);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // expectation uses the register values before this edge's write
            if (start && !busy)
                coord_queue.insert(coord_queue.size(), map_coord(req));
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    cwm_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[12:0];
                    cwm_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[12:0];
                    cwm_pkg::REG_FOCAL_LENGTH: focal_q  <= pwdata[17:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

@@ tb/tb_cylindrical_warp_map_generator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cylindrical_warp_map_generator
// Drives coordinates and register settings into the warp map generator and
// leaves the checking to cwm_checker; reports the verdict.
// ----------------------------------------------------------------------------
module tb_cylindrical_warp_map_generator;

    localparam int RANDOM_ITEMS = 1600;
    localparam longint CYCLE_LIMIT = 400000;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    cwm_pkg::req_t req;
    logic          done;
    cwm_pkg::rsp_t rsp;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [3:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    int            fail_count;
    int            pending;
    int            mapped_count;
    int            result_count;
    int            sent_count;
    int            idle_pct;
    longint        cycle_count;
    logic [12:0]   cur_w;
    logic [12:0]   cur_h;

    cylindrical_warp_map_generator uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    cwm_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending),
        .mapped_count(mapped_count), .result_count(result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == cwm_pkg::REG_IMAGE_WIDTH)
            cur_w = val[12:0];
        if (idx == cwm_pkg::REG_IMAGE_HEIGHT)
            cur_h = val[12:0];
    endtask

    // holds start high through one accepted transfer and leaves it high; a later idle cycle or drain() drops it
    task automatic send_coord(input logic [11:0] c, input logic [11:0] r);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        req.col <= c;
        req.row <= r;
        do
            @(posedge clk);
        while (busy);
        sent_count++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (cwm_pkg::LATENCY + 4) @(posedge clk);
    endtask

    // mostly coordinates inside the current map, some anywhere in the field
    task automatic send_random();
        logic [11:0] c;
        logic [11:0] r;
        if ($urandom_range(9, 0) < 8)
        begin
            c = 12'($urandom_range((cur_w > 4096) ? 4095 : cur_w - 1, 0));
            r = 12'($urandom_range((cur_h > 4096) ? 4095 : cur_h - 1, 0));
        end
        else
        begin
            c = 12'($urandom);
            r = 12'($urandom);
        end
        send_coord(c, r);
    endtask

    initial
    begin
        logic [31:0] fl;
        rst_n = 1'b0; start = 1'b0; req = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cycle_count = 0; sent_count = 0; idle_pct = 0;
        cur_w = 13'd640; cur_h = 13'd480;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: corners, center, points past the edges
        send_coord(12'd0, 12'd0);
        send_coord(12'd639, 12'd479);
        send_coord(12'd320, 12'd240);
        send_coord(12'd640, 12'd0);
        send_coord(12'd0, 12'd480);
        send_coord(12'd4095, 12'd4095);
        send_coord(12'd321, 12'd100);
        drain();
        // odd sizes leave the last line unmapped; short focal length reaches the right angle
        write_reg(cwm_pkg::REG_IMAGE_WIDTH, 32'd7);
        write_reg(cwm_pkg::REG_IMAGE_HEIGHT, 32'd5);
        write_reg(cwm_pkg::REG_FOCAL_LENGTH, 32'd16);
        send_coord(12'd6, 12'd0);
        send_coord(12'd0, 12'd4);
        send_coord(12'd3, 12'd2);
        send_coord(12'd0, 12'd2);
        send_coord(12'd5, 12'd3);
        drain();
        write_reg(cwm_pkg::REG_FOCAL_LENGTH, 32'd0);
        send_coord(12'd3, 12'd2);
        drain();
        // largest dimensions and focal length, widths past the limit wrap
        write_reg(cwm_pkg::REG_IMAGE_WIDTH, 32'd8191);
        write_reg(cwm_pkg::REG_IMAGE_HEIGHT, 32'd8191);
        write_reg(cwm_pkg::REG_FOCAL_LENGTH, 32'h3FFFF);
        send_coord(12'd4095, 12'd4095);
        send_coord(12'd0, 12'd0);
        send_coord(12'hAAA, 12'h555);
        send_coord(12'h555, 12'hAAA);
        drain();
        write_reg(cwm_pkg::REG_IMAGE_WIDTH, 32'd2);
        write_reg(cwm_pkg::REG_IMAGE_HEIGHT, 32'd2);
        send_coord(12'd0, 12'd0);
        send_coord(12'd1, 12'd1);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            idle_pct = (ph < 3) ? 8 : ((ph < 6) ? 62 : 0);
            case (ph % 4)
                0: fl = $urandom_range(12000, 16);
                1: fl = $urandom_range(262143, 16);
                2: fl = 32'd16;
                default: fl = 32'h3FFFF;
            endcase
            write_reg(cwm_pkg::REG_IMAGE_WIDTH,
                      (ph == 7) ? 32'd4096 : 32'($urandom_range(700, 2)));
            write_reg(cwm_pkg::REG_IMAGE_HEIGHT,
                      (ph == 7) ? 32'd4096 : 32'($urandom_range(700, 2)));
            write_reg(cwm_pkg::REG_FOCAL_LENGTH, fl);
            for (int n = 0; n < RANDOM_ITEMS / 8; n++)
                send_random();
            drain();
        end

        $display("sent %0d coordinates, %0d results, %0d inside the source image",
                 sent_count, result_count, mapped_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ cylindrical_warp_map_generator.f @@
design/cwm_pkg.sv
design/cwm_cordic.sv
design/cylindrical_warp_map_generator.sv
tb/cwm_checker.sv
tb/tb_cylindrical_warp_map_generator.sv
